>>> rtl/fdd_pkg.sv
// Shared types and constants for the sync-byte deframer with dual checksums.
`timescale 1ns / 1ps

package fdd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hAA;
    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 16'd5;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_GOOD      = 3'd1,
        EV_HDR_BAD   = 3'd2,
        EV_BODY_BAD  = 3'd3,
        EV_LEN_SHORT = 3'd4
    } t_event;

    typedef enum logic [5:0] {
        ST_HUNT    = 6'b000001,
        ST_LEN_HI  = 6'b000010,
        ST_LEN_LO  = 6'b000100,
        ST_HDR_CS  = 6'b001000,
        ST_BODY    = 6'b010000,
        ST_BODY_CS = 6'b100000
    } t_state;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

    // one result from the parser toward the output buffer
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_beat;

endpackage

>>> rtl/fdd_if.sv
// Valid/ready stream interfaces for received bytes and deframer events.
`timescale 1ns / 1ps

interface fdd_rx_if
    import fdd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdd_ev_if
    import fdd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        event_res;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_length;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_length, output ready);
endinterface

>>> rtl/fdd_parser.sv
// Frame parser: sync hunt, length and header checksum, payload and body checksum.
`timescale 1ns / 1ps

module fdd_parser
    import fdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_res_beat         o_res
);

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [LEN_W-1:0]  r_cnt,   n_cnt;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    t_res_beat         r_res,   n_res;

    logic [BYTE_W-1:0] sum_add;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  cnt_inc;

    assign sum_add = BYTE_W'(r_sum + i_rx_byte);
    assign plen    = LEN_W'(r_len - MIN_FRAME_LEN);
    assign cnt_inc = LEN_W'(r_cnt + LEN_W'(1));

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_res   = '0;
        if (i_beat) begin
            case (r_state)
                ST_LEN_HI: begin
                    n_len   = {i_rx_byte, 8'h00};
                    n_sum   = sum_add;
                    n_state = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    n_len   = {r_len[LEN_W-1:BYTE_W], i_rx_byte};
                    n_sum   = sum_add;
                    n_state = ST_HDR_CS;
                end
                ST_HDR_CS: begin
                    n_sum = sum_add;
                    // header checksum is judged before the length
                    if (sum_add != '0) begin
                        n_state             = ST_HUNT;
                        n_res.valid         = 1'b1;
                        n_res.res.event_res = EV_HDR_BAD;
                    end else if (r_len < MIN_FRAME_LEN) begin
                        n_state             = ST_HUNT;
                        n_res.valid         = 1'b1;
                        n_res.res.event_res = EV_LEN_SHORT;
                    end else begin
                        n_cnt   = '0;
                        n_state = (r_len == MIN_FRAME_LEN) ? ST_BODY_CS : ST_BODY;
                    end
                end
                ST_BODY: begin
                    n_sum = sum_add;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= plen) begin
                        n_state = ST_BODY_CS;
                    end
                    n_res.valid              = 1'b1;
                    n_res.res.event_res      = EV_PAYLOAD;
                    n_res.res.payload_byte   = i_rx_byte;
                    n_res.res.payload_length = plen;
                end
                ST_BODY_CS: begin
                    n_sum                    = sum_add;
                    n_state                  = ST_HUNT;
                    n_res.valid              = 1'b1;
                    n_res.res.event_res      = (sum_add == '0) ? EV_GOOD : EV_BODY_BAD;
                    n_res.res.payload_length = plen;
                end
                default: begin
                    if (i_rx_byte == SYNC_BYTE) begin
                        n_sum   = SYNC_BYTE;
                        n_len   = '0;
                        n_cnt   = '0;
                        n_state = ST_LEN_HI;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/fdd_out_buf.sv
// Two-entry output buffer: output register plus skid register.
`timescale 1ns / 1ps

module fdd_out_buf
    import fdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_beat i_res,
    output logic      o_in_ready,
    output t_res_beat o_out,
    input  logic      i_out_ready
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop        = r_out_valid && i_out_ready;
    // a byte taken now lands here next cycle, so after this edge at most one
    // entry may be held: no room while the skid is full, or while the output
    // stays held and the parser result moves in behind it
    assign o_in_ready = !r_skid_valid && !(r_out_valid && i_res.valid && !pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res.valid;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= i_res.valid;
        end else if (i_res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_valid ? r_skid : i_res.res;
        end else if (!r_out_valid) begin
            r_out <= i_res.res;
        end else if (i_res.valid) begin
            r_skid <= i_res.res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.res   = r_out;

endmodule

>>> rtl/frame_deframer_dual_checksum.sv
// Top level of the sync-byte deframer with header and body checksums.
`timescale 1ns / 1ps

// Takes one received byte per beat and can accept a byte every clock cycle.
// The parser decodes each accepted byte against its state: it hunts for sync
// 0xAA, reads a big-endian 16-bit total length and a header checksum, forwards
// payload bytes (event 0) and closes the frame with good, header-bad, body-bad
// or length-short events; the event is captured in the parser result register.
// A result passes the parser register, then the output register, before it
// can leave. A skid register behind the output absorbs the result still in
// the parser register when the event side stalls. Input ready drops while
// the skid slot is full, or while the output register is held and a result
// is on its way into the buffer; it follows event-side ready combinationally,
// so with the event side ready a steady stream runs at one byte per cycle.

module frame_deframer_dual_checksum
    import fdd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    fdd_rx_if.sink   i_rx,
    fdd_ev_if.source o_ev
);

    logic      in_ready;
    logic      beat;
    t_res_beat res;
    t_res_beat out;

    assign beat       = i_rx.valid && in_ready;
    assign i_rx.ready = in_ready;

    fdd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_rx_byte (i_rx.rx_byte),
        .o_res     (res)
    );

    fdd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_in_ready  (in_ready),
        .o_out       (out),
        .i_out_ready (o_ev.ready)
    );

    assign o_ev.valid          = out.valid;
    assign o_ev.event_res      = out.res.event_res;
    assign o_ev.payload_byte   = out.res.payload_byte;
    assign o_ev.payload_length = out.res.payload_length;

endmodule
